/* rtl/qfn_pkg.sv */
// ----------------------------------------------------------------------------
// qfn_pkg: shared types and constants for the quad face unit normal block
// Widths of every pipeline stage follow from the coordinate and fraction sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package qfn_pkg;

  localparam int CB  = 16;          // coordinate bits used from each field
  localparam int FB  = 14;          // fraction bits of the unit normal
  localparam int OB  = 16;          // output component width
  localparam int D_W = CB + 1;      // diagonal component
  localparam int P_W = 2 * D_W;     // diagonal product
  localparam int N_W = P_W + 1;     // cross product component, signed
  localparam int A_W = N_W - 1;     // cross product magnitude per axis
  localparam int L_W = (A_W + 1) / 2;   // low half for split squaring
  localparam int H_W = A_W - L_W;       // high half
  localparam int Q2_W = 2 * A_W;        // one square
  localparam int S_W = 2 * A_W + 2;     // sum of three squares (even)
  localparam int M_W = S_W / 2;         // square root width
  localparam int Q_W = FB + 1;          // quotient width

  localparam longint UNIT_ONE = longint'(1) << FB;
  localparam longint POS_MAX  = (longint'(1) << (OB - 1)) - 1;
  localparam longint NEG_MAX  = longint'(1) << (OB - 1);

  typedef struct packed {
    logic signed [15:0] corner1_x;
    logic signed [15:0] corner1_y;
    logic signed [15:0] corner1_z;
    logic signed [15:0] corner2_x;
    logic signed [15:0] corner2_y;
    logic signed [15:0] corner2_z;
    logic signed [15:0] corner3_x;
    logic signed [15:0] corner3_y;
    logic signed [15:0] corner3_z;
    logic signed [15:0] corner4_x;
    logic signed [15:0] corner4_y;
    logic signed [15:0] corner4_z;
  } qfn_in_t;

  typedef struct packed {
    logic signed [OB-1:0] normal_x;
    logic signed [OB-1:0] normal_y;
    logic signed [OB-1:0] normal_z;
    logic                 degenerate;
  } qfn_out_t;

  // cross product as magnitudes plus sign bits
  typedef struct packed {
    logic [A_W-1:0] ax;
    logic [A_W-1:0] ay;
    logic [A_W-1:0] az;
    logic           nx;
    logic           ny;
    logic           nz;
  } nvec_t;

  typedef struct packed {
    nvec_t          n;
    logic [S_W-1:0] s;
  } sumsq_t;

  typedef struct packed {
    nvec_t          n;
    logic [M_W-1:0] mag;
  } magvec_t;

  // clamp a quotient to the unit range and the output range, apply sign
  function automatic logic signed [OB-1:0] sat_comp(input logic [Q_W-1:0] q,
                                                    input logic neg);
    longint v;
    v = longint'(q);
    if (v > UNIT_ONE) v = UNIT_ONE;
    if (neg) begin
      if (v > NEG_MAX) v = NEG_MAX;
      v = -v;
    end else begin
      if (v > POS_MAX) v = POS_MAX;
    end
    return OB'(v);
  endfunction

endpackage
`default_nettype wire

/* rtl/qfn_front.sv */
// ----------------------------------------------------------------------------
// qfn_front: diagonals, cross product and sum of squares
// Six stages: diff, products, cross/abs, partial squares, squares, sum.
// ----------------------------------------------------------------------------
`default_nettype none
module qfn_front import qfn_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    in_v,
  input  wire qfn_in_t in_d,
  output logic         out_v,
  output sumsq_t       out_d
);

  function automatic logic signed [D_W-1:0] ext(input logic [15:0] f);
    return D_W'($signed(f[CB-1:0]));
  endfunction

  logic [5:0] v_r;
  logic signed [D_W-1:0] d_r [6];
  logic signed [P_W-1:0] p_r [6];
  nvec_t n3_r, n4_r, n5_r;
  logic [2*H_W-1:0]     hh_r [3];
  logic [H_W+L_W-1:0]   hl_r [3];
  logic [2*L_W-1:0]     ll_r [3];
  logic [Q2_W-1:0]      sq_r [3];
  sumsq_t s_r;

  logic signed [N_W-1:0] cx, cy, cz;
  logic [A_W-1:0] aa [3];

  always_comb begin
    cx = N_W'(p_r[0]) - N_W'(p_r[1]);
    cy = N_W'(p_r[2]) - N_W'(p_r[3]);
    cz = N_W'(p_r[4]) - N_W'(p_r[5]);
    aa[0] = n3_r.ax;
    aa[1] = n3_r.ay;
    aa[2] = n3_r.az;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_v};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // diagonals d1 = c3 - c1, d2 = c4 - c2
      d_r[0] <= ext(in_d.corner3_x) - ext(in_d.corner1_x);
      d_r[1] <= ext(in_d.corner3_y) - ext(in_d.corner1_y);
      d_r[2] <= ext(in_d.corner3_z) - ext(in_d.corner1_z);
      d_r[3] <= ext(in_d.corner4_x) - ext(in_d.corner2_x);
      d_r[4] <= ext(in_d.corner4_y) - ext(in_d.corner2_y);
      d_r[5] <= ext(in_d.corner4_z) - ext(in_d.corner2_z);
      // cross product terms
      p_r[0] <= d_r[1] * d_r[5];
      p_r[1] <= d_r[2] * d_r[4];
      p_r[2] <= d_r[2] * d_r[3];
      p_r[3] <= d_r[0] * d_r[5];
      p_r[4] <= d_r[0] * d_r[4];
      p_r[5] <= d_r[1] * d_r[3];
      // magnitude and sign
      n3_r.nx <= cx[N_W-1];
      n3_r.ny <= cy[N_W-1];
      n3_r.nz <= cz[N_W-1];
      n3_r.ax <= cx[N_W-1] ? A_W'(-cx) : A_W'(cx);
      n3_r.ay <= cy[N_W-1] ? A_W'(-cy) : A_W'(cy);
      n3_r.az <= cz[N_W-1] ? A_W'(-cz) : A_W'(cz);
      n4_r <= n3_r;
      n5_r <= n4_r;
      s_r.n <= n5_r;
      // square split into half-width partial products
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= aa[i][A_W-1:L_W] * aa[i][A_W-1:L_W];
        hl_r[i] <= aa[i][A_W-1:L_W] * aa[i][L_W-1:0];
        ll_r[i] <= aa[i][L_W-1:0] * aa[i][L_W-1:0];
        sq_r[i] <= (Q2_W'(hh_r[i]) << (2 * L_W)) + (Q2_W'(hl_r[i]) << (L_W + 1))
                   + Q2_W'(ll_r[i]);
      end
      s_r.s <= S_W'(sq_r[0]) + S_W'(sq_r[1]) + S_W'(sq_r[2]);
    end
  end

  assign out_v = v_r[5];
  assign out_d = s_r;

endmodule
`default_nettype wire

/* rtl/qfn_sqrt.sv */
// ----------------------------------------------------------------------------
// qfn_sqrt: pipelined integer square root
// One root bit per stage, M_W stages, floor result.
// ----------------------------------------------------------------------------
`default_nettype none
module qfn_sqrt import qfn_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire logic   in_v,
  input  wire sumsq_t in_d,
  output logic        out_v,
  output magvec_t     out_d
);

  localparam int RW = M_W + 3;

  typedef struct packed {
    nvec_t          n;
    logic [S_W-1:0] s;
    logic [RW-1:0]  rem;
    logic [M_W-1:0] root;
  } sqst_t;

  sqst_t      src [M_W];
  sqst_t      nxt [M_W];
  sqst_t      pipe_r [M_W];
  logic [M_W-1:0] v_r;

  assign src[0] = '{n: in_d.n, s: in_d.s, rem: '0, root: '0};

  genvar k;
  generate
    for (k = 0; k < M_W; k++) begin : g_stage
      if (k > 0) begin : g_src
        assign src[k] = pipe_r[k-1];
      end

      logic [RW-1:0] r2, trial;
      // one digit step: bring down two bits, try root*4+1
      always_comb begin
        r2    = {src[k].rem[RW-3:0], src[k].s[S_W-1 -: 2]};
        trial = {1'b0, src[k].root, 2'b01};
        nxt[k].n = src[k].n;
        nxt[k].s = src[k].s << 2;
        if (r2 >= trial) begin
          nxt[k].rem  = r2 - trial;
          nxt[k].root = {src[k].root[M_W-2:0], 1'b1};
        end else begin
          nxt[k].rem  = r2;
          nxt[k].root = {src[k].root[M_W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pipe_r[k] <= nxt[k];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[M_W-2:0], in_v};
    end
  end

  assign out_v     = v_r[M_W-1];
  assign out_d.n   = pipe_r[M_W-1].n;
  assign out_d.mag = pipe_r[M_W-1].root;

endmodule
`default_nettype wire

/* rtl/qfn_div.sv */
// ----------------------------------------------------------------------------
// qfn_div: three-lane pipelined divider and output saturation
// Restoring division, one quotient bit per stage, then a result register.
// ----------------------------------------------------------------------------
`default_nettype none
module qfn_div import qfn_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    in_v,
  input  wire magvec_t in_d,
  output logic         out_v,
  output qfn_out_t     out_d
);

  localparam int RD = M_W + 1;

  typedef struct packed {
    logic [M_W-1:0]         mag;
    logic [2:0][RD-1:0]     r;
    logic [2:0][Q_W-1:0]    q;
    logic [2:0]             neg;
    logic                   degen;
  } dvst_t;

  dvst_t    head;
  dvst_t    nxt [FB];
  dvst_t    pipe_r [FB+1];
  logic [FB:0] v_r;
  qfn_out_t res_r;
  logic     res_v_r;
  logic [A_W-1:0] a [3];

  // first quotient bit: integer part, 0 or 1
  always_comb begin
    a[0] = in_d.n.ax;
    a[1] = in_d.n.ay;
    a[2] = in_d.n.az;
    head.mag   = in_d.mag;
    head.neg   = {in_d.n.nz, in_d.n.ny, in_d.n.nx};
    head.degen = (in_d.mag == '0);
    for (int i = 0; i < 3; i++) begin
      if (RD'(a[i]) >= RD'(in_d.mag)) begin
        head.r[i] = RD'(a[i]) - RD'(in_d.mag);
        head.q[i] = Q_W'(1);
      end else begin
        head.r[i] = RD'(a[i]);
        head.q[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= head;
    end
  end

  genvar k;
  generate
    for (k = 0; k < FB; k++) begin : g_stage
      // fraction bit: shift remainder, trial subtract
      always_comb begin
        logic [RD-1:0] r2;
        nxt[k] = pipe_r[k];
        for (int i = 0; i < 3; i++) begin
          r2 = pipe_r[k].r[i] << 1;
          if (r2 >= RD'(pipe_r[k].mag)) begin
            nxt[k].r[i] = r2 - RD'(pipe_r[k].mag);
            nxt[k].q[i] = {pipe_r[k].q[i][Q_W-2:0], 1'b1};
          end else begin
            nxt[k].r[i] = r2;
            nxt[k].q[i] = {pipe_r[k].q[i][Q_W-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pipe_r[k+1] <= nxt[k];
        end
      end
    end
  endgenerate

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      res_v_r <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[FB-1:0], in_v};
      res_v_r <= v_r[FB];
    end
  end

  // saturate, zero on degenerate face
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.degenerate <= pipe_r[FB].degen;
      if (pipe_r[FB].degen) begin
        res_r.normal_x <= '0;
        res_r.normal_y <= '0;
        res_r.normal_z <= '0;
      end else begin
        res_r.normal_x <= sat_comp(pipe_r[FB].q[0], pipe_r[FB].neg[0]);
        res_r.normal_y <= sat_comp(pipe_r[FB].q[1], pipe_r[FB].neg[1]);
        res_r.normal_z <= sat_comp(pipe_r[FB].q[2], pipe_r[FB].neg[2]);
      end
    end
  end

  assign out_v = res_v_r;
  assign out_d = res_r;

endmodule
`default_nettype wire

/* rtl/quad_face_unit_normal_unit.sv */
// ----------------------------------------------------------------------------
// quad_face_unit_normal_unit: unit normal of a quad face
// Cross product of the diagonals, normalized to Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries the four corners of one
//   face. Output channel out_valid/out_ready/out_data carries the normal and
//   a degenerate flag (set, with zero components, when the cross product
//   is the zero vector).
//   From acceptance to out_valid an item passes the register stages of
//   diagonals, products and sum of squares, then those of the square root
//   (one root bit each), then those of division (one quotient bit each) and
//   the output register; every stage is a register stage.
//   Throughput is one item per cycle while the receiver does not stall.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits; no item is in
//   flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none
module quad_face_unit_normal_unit import qfn_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire qfn_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output qfn_out_t      out_data
);

  logic    en;
  logic    f_v, s_v;
  sumsq_t  f_d;
  magvec_t s_d;

  // pipeline advances unless a result is held back
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  qfn_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(in_valid), .in_d(in_data),
    .out_v(f_v), .out_d(f_d)
  );

  qfn_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(f_v), .in_d(f_d),
    .out_v(s_v), .out_d(s_d)
  );

  qfn_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(s_v), .in_d(s_d),
    .out_v(out_valid), .out_d(out_data)
  );

endmodule
`default_nettype wire

/* rtl/qfn_checker.sv */
// ----------------------------------------------------------------------------
// qfn_checker: port-level checks for the quad face unit normal block
// Attached to the top level by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none
module qfn_checker import qfn_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire qfn_out_t out_data
);

  localparam logic signed [OB-1:0] ONE_P = OB'(UNIT_ONE);
  localparam logic signed [OB-1:0] ONE_N = -OB'(UNIT_ONE);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("held result changed");

  // a stalled output blocks new input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  // degenerate face gives a zero normal
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("degenerate face with nonzero normal");

  // components stay within the unit range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.normal_x <= ONE_P && out_data.normal_x >= ONE_N &&
      out_data.normal_y <= ONE_P && out_data.normal_y >= ONE_N &&
      out_data.normal_z <= ONE_P && out_data.normal_z >= ONE_N)
    else $error("normal component out of range");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind quad_face_unit_normal_unit qfn_checker u_qfn_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
`default_nettype wire
